/* src/tcw_pkg.sv */
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

   localparam int ROWS        = 25;
   localparam int COLS        = 80;
   localparam int CELLS       = ROWS * COLS;
   localparam int COPY_CELLS  = CELLS - COLS;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int COL_W       = $clog2(COLS);
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int CHAR_W      = 8;
   localparam int COLOUR_W    = 8;
   localparam int MODE_W      = 3;
   localparam int POS_W       = 7;
   localparam int CSR_IDX_W   = 8;

   localparam logic [CHAR_W-1:0]   CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0]   CH_ERROR   = 8'h45;
   localparam logic [CHAR_W-1:0]   CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0]   CH_BLANK   = 8'h08;

   localparam logic [COLOUR_W-1:0] RESET_DEFAULT_COLOUR = 8'd15;
   localparam logic [COLOUR_W-1:0] RESET_ERROR_COLOUR   = 8'd244;

   localparam logic [MODE_W-1:0] MODE_PUT_CURSOR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUT_AT     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BACKSPACE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_COLOUR = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_COLOUR   = 8'd1;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic                clear;
      logic                scroll;
      logic                err;
      logic [ADDR_W-1:0]   addr;
      logic [CHAR_W-1:0]   wr_char;
      logic [COLOUR_W-1:0] wr_colour;
      logic [ROW_W-1:0]    cursor_row;
      logic [COL_W-1:0]    cursor_col;
   } tcw_plan_type;

endpackage

/* src/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcw_decode.sv */
// Decode of one request into the cell access, cursor update and flags it causes.
module tcw_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [tcw_pkg::MODE_W-1:0]       mode,
   input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
   input  logic [tcw_pkg::POS_W-1:0]        row,
   input  logic [tcw_pkg::POS_W-1:0]        col,
   input  logic [tcw_pkg::COLOUR_W-1:0]     colour,
   input  logic [tcw_pkg::ROW_W-1:0]        cursor_row,
   input  logic [tcw_pkg::COL_W-1:0]        cursor_col,
   input  logic [tcw_pkg::COLOUR_W-1:0]     default_colour,
   input  logic [tcw_pkg::COLOUR_W-1:0]     error_colour,
   output tcw_pkg::tcw_plan_type            plan
);

   tcw_pkg::tcw_plan_type             plan_ff;
   tcw_pkg::tcw_plan_type             plan_in;
   logic                              in_range;
   logic                              is_put;
   logic [tcw_pkg::ROW_W-1:0]         base_row;
   logic [tcw_pkg::COL_W-1:0]         base_col;
   logic [tcw_pkg::CHAR_W-1:0]        put_char;
   logic [tcw_pkg::COLOUR_W-1:0]      put_colour;
   logic [tcw_pkg::ADDR_W-1:0]        base_addr;
   logic [tcw_pkg::ROW_W:0]           next_row;
   logic [tcw_pkg::COL_W-1:0]         next_col;

   assign in_range = ({1'b0, row} < 8'(tcw_pkg::ROWS)) && ({1'b0, col} < 8'(tcw_pkg::COLS));

   always_comb begin
      is_put     = 1'b0;
      base_row   = cursor_row;
      base_col   = cursor_col;
      put_char   = char_code;
      put_colour = (colour == '0) ? default_colour : colour;
      next_row   = (tcw_pkg::ROW_W+1)'(cursor_row);
      next_col   = cursor_col;
      plan_in    = '0;
      plan_in.cursor_row = cursor_row;
      plan_in.cursor_col = cursor_col;

      case (mode)
         tcw_pkg::MODE_PUT_CURSOR: begin
            is_put = 1'b1;
         end
         tcw_pkg::MODE_PUT_AT: begin
            base_row = tcw_pkg::ROW_W'(row);
            base_col = tcw_pkg::COL_W'(col);
            if (in_range) begin
               is_put = 1'b1;
            end else begin
               plan_in.wr_en     = 1'b1;
               plan_in.err       = 1'b1;
               plan_in.addr      = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
               plan_in.wr_char   = tcw_pkg::CH_ERROR;
               plan_in.wr_colour = error_colour;
            end
         end
         tcw_pkg::MODE_BACKSPACE: begin
            is_put     = 1'b1;
            put_char   = tcw_pkg::CH_BLANK;
            put_colour = default_colour;
            if (cursor_col != '0) begin
               base_col = cursor_col - tcw_pkg::COL_W'(1);
            end else if (cursor_row != '0) begin
               base_row = cursor_row - tcw_pkg::ROW_W'(1);
               base_col = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
            end
         end
         tcw_pkg::MODE_CLEAR: begin
            plan_in.clear      = 1'b1;
            plan_in.cursor_row = '0;
            plan_in.cursor_col = '0;
         end
         tcw_pkg::MODE_READ: begin
            base_row = tcw_pkg::ROW_W'(row);
            base_col = tcw_pkg::COL_W'(col);
            if (in_range) begin
               plan_in.rd_en = 1'b1;
            end else begin
               plan_in.err = 1'b1;
            end
         end
         default: begin
         end
      endcase

      base_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(base_row) *
                                   tcw_pkg::ADDR_W'(tcw_pkg::COLS))
                + tcw_pkg::ADDR_W'(base_col);
      if (plan_in.rd_en) begin
         plan_in.addr = base_addr;
      end

      if (is_put) begin
         plan_in.addr      = base_addr;
         plan_in.wr_colour = put_colour;
         if (put_char == tcw_pkg::CH_NEWLINE) begin
            next_row = (tcw_pkg::ROW_W+1)'(base_row) + (tcw_pkg::ROW_W+1)'(1);
            next_col = '0;
         end else if (put_char == tcw_pkg::CH_BLANK) begin
            plan_in.wr_en   = 1'b1;
            plan_in.wr_char = tcw_pkg::CH_SPACE;
            next_row        = (tcw_pkg::ROW_W+1)'(base_row);
            next_col        = base_col;
         end else begin
            plan_in.wr_en   = 1'b1;
            plan_in.wr_char = put_char;
            if (base_col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) begin
               next_row = (tcw_pkg::ROW_W+1)'(base_row) + (tcw_pkg::ROW_W+1)'(1);
               next_col = '0;
            end else begin
               next_row = (tcw_pkg::ROW_W+1)'(base_row);
               next_col = base_col + tcw_pkg::COL_W'(1);
            end
         end
         if (next_row == (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
            plan_in.scroll     = 1'b1;
            plan_in.cursor_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
         end else begin
            plan_in.cursor_row = tcw_pkg::ROW_W'(next_row);
         end
         plan_in.cursor_col = next_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_ff <= '0;
      end else if (load) begin
         plan_ff <= plan_in;
      end
   end

   assign plan = plan_ff;

endmodule

/* src/text_console_writer.sv */
// Top level of the text console writer: control sequencer, screen memories, ports.
// A request is decoded into a registered plan, applied in the access state and answered from the response registers.
// A scroll sweeps every cell (row copy and last-row blank through the memories).
// A clear writes every cell with a space in the default colour (one cell written per cycle).
// Reset: cursor to cell zero, colours to 15 and 244, then a pass over every cell
// fills the screen with spaces in colour 15 while req_stall stays high.
module text_console_writer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::MODE_W-1:0]       req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::POS_W-1:0]        req_row,
   input  logic [tcw_pkg::POS_W-1:0]        req_col,
   input  logic [tcw_pkg::COLOUR_W-1:0]     req_colour,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::POS_W-1:0]        rsp_cursor_col,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   output logic [tcw_pkg::COLOUR_W-1:0]     rsp_cell_colour,
   output logic                             rsp_range_error,
   output logic                             rsp_scrolled,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcw_pkg::COLOUR_W-1:0]     csr_data
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ACCESS = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [tcw_pkg::ADDR_W-1:0]        scan_ff, scan_in;
   logic                              wb_valid_ff, wb_valid_in;
   logic                              wb_copy_ff, wb_copy_in;
   logic [tcw_pkg::ADDR_W-1:0]        wb_addr_ff, wb_addr_in;
   logic [tcw_pkg::ROW_W-1:0]         cursor_row_ff, cursor_row_in;
   logic [tcw_pkg::COL_W-1:0]         cursor_col_ff, cursor_col_in;
   logic [tcw_pkg::COLOUR_W-1:0]      default_colour_ff, default_colour_in;
   logic [tcw_pkg::COLOUR_W-1:0]      error_colour_ff, error_colour_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]         rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [tcw_pkg::POS_W-1:0]         rsp_cursor_col_ff, rsp_cursor_col_in;
   logic [tcw_pkg::CHAR_W-1:0]        rsp_cell_char_ff, rsp_cell_char_in;
   logic [tcw_pkg::COLOUR_W-1:0]      rsp_cell_colour_ff, rsp_cell_colour_in;
   logic                              rsp_range_error_ff, rsp_range_error_in;
   logic                              rsp_scrolled_ff, rsp_scrolled_in;

   logic                              req_transfer;
   logic                              rsp_load;
   logic                              scan_last;
   logic                              scan_copy;
   tcw_pkg::tcw_plan_type             plan;

   logic                              char_wr_en;
   logic                              colour_wr_en;
   logic [tcw_pkg::ADDR_W-1:0]        mem_wr_addr;
   logic [tcw_pkg::CHAR_W-1:0]        char_wr_data;
   logic [tcw_pkg::COLOUR_W-1:0]      colour_wr_data;
   logic                              mem_rd_en;
   logic [tcw_pkg::ADDR_W-1:0]        mem_rd_addr;
   logic [tcw_pkg::CHAR_W-1:0]        char_rd_data;
   logic [tcw_pkg::COLOUR_W-1:0]      colour_rd_data;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_transfer = req_valid && !req_stall;
   assign csr_ready    = 1'b1;
   assign scan_last    = (scan_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
   assign scan_copy    = (scan_ff < tcw_pkg::ADDR_W'(tcw_pkg::COPY_CELLS));
   assign rsp_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   tcw_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .load           (req_transfer),
      .mode           (req_mode),
      .char_code      (req_char_code),
      .row            (req_row),
      .col            (req_col),
      .colour         (req_colour),
      .cursor_row     (cursor_row_ff),
      .cursor_col     (cursor_col_ff),
      .default_colour (default_colour_ff),
      .error_colour   (error_colour_ff),
      .plan           (plan)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::CHAR_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (char_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (char_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (char_rd_data)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::COLOUR_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_colour_ram (
      .clock   (clock),
      .wr_en   (colour_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (colour_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (colour_rd_data)
   );

   always_comb begin
      char_wr_en     = 1'b0;
      colour_wr_en   = 1'b0;
      mem_wr_addr    = scan_ff;
      char_wr_data   = tcw_pkg::CH_SPACE;
      colour_wr_data = default_colour_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = scan_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
      case (state_ff)
         ST_INIT: begin
            char_wr_en     = 1'b1;
            colour_wr_en   = 1'b1;
            colour_wr_data = tcw_pkg::RESET_DEFAULT_COLOUR;
         end
         ST_CLEAR: begin
            char_wr_en   = 1'b1;
            colour_wr_en = 1'b1;
         end
         ST_ACCESS: begin
            char_wr_en     = plan.wr_en;
            colour_wr_en   = plan.wr_en;
            mem_wr_addr    = plan.addr;
            char_wr_data   = plan.wr_char;
            colour_wr_data = plan.wr_colour;
            mem_rd_en      = plan.rd_en;
            mem_rd_addr    = plan.addr;
         end
         ST_SCROLL: begin
            mem_rd_en = scan_copy;
         end
         default: begin
         end
      endcase
      // write back the row copy, or blank a last-row character
      if (wb_valid_ff) begin
         char_wr_en     = 1'b1;
         colour_wr_en   = wb_copy_ff;
         mem_wr_addr    = wb_addr_ff;
         char_wr_data   = wb_copy_ff ? char_rd_data : tcw_pkg::CH_SPACE;
         colour_wr_data = colour_rd_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      wb_valid_in   = 1'b0;
      wb_copy_in    = wb_copy_ff;
      wb_addr_in    = wb_addr_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      case (state_ff)
         ST_INIT: begin
            scan_in = scan_ff + tcw_pkg::ADDR_W'(1);
            if (scan_last) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_transfer) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cursor_row_in = plan.cursor_row;
            cursor_col_in = plan.cursor_col;
            scan_in       = '0;
            if (plan.clear) begin
               state_in = ST_CLEAR;
            end else if (plan.scroll) begin
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL: begin
            wb_valid_in = 1'b1;
            wb_copy_in  = scan_copy;
            wb_addr_in  = scan_ff;
            scan_in     = scan_ff + tcw_pkg::ADDR_W'(1);
            if (scan_last) begin
               scan_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            scan_in = scan_ff + tcw_pkg::ADDR_W'(1);
            if (scan_last) begin
               scan_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      default_colour_in = default_colour_ff;
      error_colour_in   = error_colour_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == tcw_pkg::CSR_DEFAULT_COLOUR) begin
            default_colour_in = csr_data;
         end else if (csr_index == tcw_pkg::CSR_ERROR_COLOUR) begin
            error_colour_in = csr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_cursor_row_in  = tcw_pkg::POS_W'(cursor_row_ff);
      rsp_cursor_col_in  = tcw_pkg::POS_W'(cursor_col_ff);
      rsp_cell_char_in   = plan.rd_en ? char_rd_data : '0;
      rsp_cell_colour_in = plan.rd_en ? colour_rd_data : '0;
      rsp_range_error_in = plan.err;
      rsp_scrolled_in    = plan.scroll;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_INIT;
         scan_ff           <= '0;
         wb_valid_ff       <= 1'b0;
         cursor_row_ff     <= '0;
         cursor_col_ff     <= '0;
         default_colour_ff <= tcw_pkg::RESET_DEFAULT_COLOUR;
         error_colour_ff   <= tcw_pkg::RESET_ERROR_COLOUR;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         scan_ff           <= scan_in;
         wb_valid_ff       <= wb_valid_in;
         cursor_row_ff     <= cursor_row_in;
         cursor_col_ff     <= cursor_col_in;
         default_colour_ff <= default_colour_in;
         error_colour_ff   <= error_colour_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_copy_ff <= wb_copy_in;
      wb_addr_ff <= wb_addr_in;
      if (rsp_load) begin
         rsp_cursor_row_ff  <= rsp_cursor_row_in;
         rsp_cursor_col_ff  <= rsp_cursor_col_in;
         rsp_cell_char_ff   <= rsp_cell_char_in;
         rsp_cell_colour_ff <= rsp_cell_colour_in;
         rsp_range_error_ff <= rsp_range_error_in;
         rsp_scrolled_ff    <= rsp_scrolled_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_row  = rsp_cursor_row_ff;
   assign rsp_cursor_col  = rsp_cursor_col_ff;
   assign rsp_cell_char   = rsp_cell_char_ff;
   assign rsp_cell_colour = rsp_cell_colour_ff;
   assign rsp_range_error = rsp_range_error_ff;
   assign rsp_scrolled    = rsp_scrolled_ff;

   a_cursor_on_screen : assert property (@(posedge clock) disable iff (reset)
      (cursor_row_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ||
      (cursor_row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)))
      else $error("cursor row beyond last screen row");

   a_writeback_in_scroll : assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_SCROLL) || (state_ff == ST_FINISH))
      else $error("scroll write-back outside scroll sweep");

   a_scroll_last_row : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && plan.scroll) |=>
         (rsp_cursor_row == tcw_pkg::POS_W'(tcw_pkg::ROWS - 1)))
      else $error("scrolled response not on last row");

   a_read_no_error : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCESS) |-> !(plan.rd_en && plan.err))
      else $error("cell read issued for out-of-range position");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for text_console_writer against a cell-level screen model.
`timescale 1ns / 100ps

module tb_top;
   import tcw_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]    cursor_row;
      logic [POS_W-1:0]    cursor_col;
      logic [CHAR_W-1:0]   cell_char;
      logic [COLOUR_W-1:0] cell_colour;
      logic                range_error;
      logic                scrolled;
   } console_reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [POS_W-1:0]     req_row = '0;
   logic [POS_W-1:0]     req_col = '0;
   logic [COLOUR_W-1:0]  req_colour = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [POS_W-1:0]     rsp_cursor_row;
   logic [POS_W-1:0]     rsp_cursor_col;
   logic [CHAR_W-1:0]    rsp_cell_char;
   logic [COLOUR_W-1:0]  rsp_cell_colour;
   logic                 rsp_range_error;
   logic                 rsp_scrolled;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOUR_W-1:0]  csr_data = '0;

   logic [CHAR_W-1:0]    shadow_chars [CELLS];
   logic [COLOUR_W-1:0]  shadow_colours [CELLS];
   int unsigned          shadow_cursor;
   logic [COLOUR_W-1:0]  shadow_default;
   logic [COLOUR_W-1:0]  shadow_error;
   bit                   step_scroll;

   console_reply_type    pending_replies [$];
   int                   mismatch_count = 0;
   bit                   idle_on = 1'b1;
   int                   hold_cycles = 0;

   text_console_writer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_char_code   (req_char_code),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_colour      (req_colour),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor_row  (rsp_cursor_row),
      .rsp_cursor_col  (rsp_cursor_col),
      .rsp_cell_char   (rsp_cell_char),
      .rsp_cell_colour (rsp_cell_colour),
      .rsp_range_error (rsp_range_error),
      .rsp_scrolled    (rsp_scrolled),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #180_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned place_char(int unsigned pos, logic [CHAR_W-1:0] ch,
                                              logic [COLOUR_W-1:0] attr);
      int unsigned next_pos;
      next_pos = pos;
      if (attr == '0) attr = shadow_default;
      if (ch == CH_NEWLINE) begin
         next_pos = (pos / COLS + 1) * COLS;
      end else if (ch == CH_BLANK) begin
         shadow_chars[pos]   = CH_SPACE;
         shadow_colours[pos] = attr;
      end else begin
         shadow_chars[pos]   = ch;
         shadow_colours[pos] = attr;
         next_pos = pos + 1;
      end
      if (next_pos >= CELLS) begin
         for (int k = 0; k < COPY_CELLS; k++) begin
            shadow_chars[k]   = shadow_chars[k + COLS];
            shadow_colours[k] = shadow_colours[k + COLS];
         end
         for (int k = COPY_CELLS; k < CELLS; k++) shadow_chars[k] = CH_SPACE;
         step_scroll = 1'b1;
         next_pos = next_pos - COLS;
      end
      return next_pos;
   endfunction

   function automatic console_reply_type console_step(logic [MODE_W-1:0] mode,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [POS_W-1:0] row,
                                                      logic [POS_W-1:0] col,
                                                      logic [COLOUR_W-1:0] colour);
      console_reply_type reply;
      bit                in_bounds;
      int unsigned       pos;
      reply       = '0;
      step_scroll = 1'b0;
      in_bounds   = (int'(row) < ROWS) && (int'(col) < COLS);
      pos         = int'(row) * COLS + int'(col);
      case (mode)
         MODE_PUT_CURSOR: shadow_cursor = place_char(shadow_cursor, ch, colour);
         MODE_PUT_AT: begin
            if (in_bounds) begin
               shadow_cursor = place_char(pos, ch, colour);
            end else begin
               shadow_chars[CELLS-1]   = CH_ERROR;
               shadow_colours[CELLS-1] = shadow_error;
               reply.range_error = 1'b1;
            end
         end
         MODE_BACKSPACE: begin
            pos = (shadow_cursor > 0) ? shadow_cursor - 1 : 0;
            shadow_cursor = place_char(pos, CH_BLANK, shadow_default);
         end
         MODE_CLEAR: begin
            for (int k = 0; k < CELLS; k++) begin
               shadow_chars[k]   = CH_SPACE;
               shadow_colours[k] = shadow_default;
            end
            shadow_cursor = 0;
         end
         MODE_READ: begin
            if (in_bounds) begin
               reply.cell_char   = shadow_chars[pos];
               reply.cell_colour = shadow_colours[pos];
            end else begin
               reply.range_error = 1'b1;
            end
         end
         default: ;
      endcase
      reply.cursor_row = POS_W'(shadow_cursor / COLS);
      reply.cursor_col = POS_W'(shadow_cursor % COLS);
      reply.scrolled   = step_scroll;
      return reply;
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return CH_NEWLINE;
      if (pick < 12) return CH_BLANK;
      return CHAR_W'($urandom);
   endfunction

   function automatic logic [POS_W-1:0] random_position(int span);
      if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, span - 1));
      return POS_W'($urandom);
   endfunction

   function automatic logic [COLOUR_W-1:0] random_colour();
      if ($urandom_range(0, 6) == 0) return '0;
      return COLOUR_W'($urandom);
   endfunction

   // hold valid and payload until the transfer, then record the prediction
   task automatic send_request(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                               logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                               logic [COLOUR_W-1:0] colour);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_code <= ch;
      req_row       <= row;
      req_col       <= col;
      req_colour    <= colour;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(console_step(mode, ch, row, col, colour));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [COLOUR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_DEFAULT_COLOUR) shadow_default = value;
      else if (index == CSR_ERROR_COLOUR) shadow_error = value;
   endtask

   // let any trailing screen walk finish before touching the colours
   task automatic set_colours(logic [COLOUR_W-1:0] default_value,
                              logic [COLOUR_W-1:0] error_value);
      wait_drained();
      repeat (CELLS + 16) @(posedge clock);
      write_register(CSR_DEFAULT_COLOUR, default_value);
      write_register(CSR_ERROR_COLOUR, error_value);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_request(MODE_PUT_CURSOR, "A", '0, '0, 8'h00);
      send_request(MODE_PUT_CURSOR, 8'hFF, '0, '0, 8'hFF);
      send_request(MODE_PUT_CURSOR, 8'h00, '0, '0, 8'h01);
      send_request(MODE_PUT_CURSOR, CH_BLANK, '0, '0, 8'h5A);
      send_request(MODE_PUT_CURSOR, CH_NEWLINE, '0, '0, 8'h00);
      send_request(MODE_BACKSPACE, "q", 7'h55, 7'h2A, 8'hAA);
      send_request(MODE_READ, '0, '0, '0, '0);
      send_request(MODE_READ, '0, '0, 7'd1, '0);
      send_request(MODE_READ, '0, '0, 7'd2, '0);
      send_request(MODE_PUT_AT, "x", 7'h7F, 7'h7F, 8'h33);
      send_request(MODE_PUT_AT, "y", '0, POS_W'(COLS), 8'h34);
      send_request(MODE_READ, '0, POS_W'(ROWS - 1), POS_W'(COLS - 1), '0);
      send_request(MODE_READ, '0, POS_W'(ROWS), '0, '0);
      send_request(MODE_READ, '0, '0, 7'h7F, '0);
      send_request(MODE_PUT_AT, "Z", POS_W'(ROWS - 1), POS_W'(COLS - 1), 8'h81);
      send_request(MODE_READ, '0, POS_W'(ROWS - 2), POS_W'(COLS - 1), '0);
      send_request(MODE_READ, '0, POS_W'(ROWS - 1), POS_W'(COLS - 1), '0);
      send_request(MODE_PUT_AT, CH_NEWLINE, POS_W'(ROWS - 1), 7'd5, 8'h00);
      send_request(MODE_PUT_AT, CH_BLANK, '0, '0, 8'h00);
      send_request(MODE_CLEAR, 8'hFF, 7'h7F, 7'h7F, 8'hFF);
      send_request(MODE_BACKSPACE, '0, '0, '0, '0);
      send_request(MODE_READ, '0, '0, '0, '0);
      for (int m = int'(MODE_READ) + 1; m < (1 << MODE_W); m++)
         send_request(MODE_W'(m), CHAR_W'($urandom), 7'h7F, 7'h7F, COLOUR_W'($urandom));
   endtask

   // place a line, type into it, then read the cells back
   task automatic test_text_lines(int lines);
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      int unsigned      start;
      int               length;
      for (int n = 0; n < lines; n++) begin
         row    = POS_W'($urandom_range(0, ROWS - 1));
         col    = POS_W'($urandom_range(0, COLS - 1));
         start  = int'(row) * COLS + int'(col);
         length = $urandom_range(1, 12);
         send_request(MODE_PUT_AT, CHAR_W'($urandom_range(8'h21, 8'h7E)), row, col,
                      random_colour());
         for (int i = 0; i < length; i++) begin
            if ($urandom_range(0, 15) == 0)
               send_request(MODE_BACKSPACE, random_char(), '0, '0, random_colour());
            else
               send_request(MODE_PUT_CURSOR,
                            ($urandom_range(0, 19) == 0) ? CH_NEWLINE
                                                         : CHAR_W'($urandom),
                            POS_W'($urandom), POS_W'($urandom), random_colour());
         end
         for (int i = 0; i <= length; i++)
            send_request(MODE_READ, CHAR_W'($urandom),
                         POS_W'(((start + i) % CELLS) / COLS),
                         POS_W'(((start + i) % CELLS) % COLS), COLOUR_W'($urandom));
      end
   endtask

   task automatic test_random_mix(int count);
      int unsigned          pick;
      logic [MODE_W-1:0]    mode;
      logic [POS_W-1:0]     row;
      logic [POS_W-1:0]     col;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         row  = random_position(ROWS);
         col  = random_position(COLS);
         if (pick < 45) begin
            mode = MODE_PUT_CURSOR;
         end else if (pick < 62) begin
            mode = MODE_PUT_AT;
         end else if (pick < 72) begin
            mode = MODE_BACKSPACE;
         end else if (pick < 91) begin
            mode = MODE_READ;
            if ($urandom_range(0, 1) == 1) row = POS_W'(shadow_cursor / COLS);
         end else if (pick < 93) begin
            mode = MODE_CLEAR;
         end else if (pick < 96) begin
            mode = MODE_W'($urandom_range(int'(MODE_READ) + 1, (1 << MODE_W) - 1));
         end else begin
            // steer toward the bottom row so that printing scrolls
            mode = MODE_PUT_AT;
            row  = POS_W'(ROWS - 1);
         end
         send_request(mode, random_char(), row, col, random_colour());
      end
   endtask

   task automatic test_backpressure(int count);
      idle_on     = 1'b0;
      hold_cycles = 400;
      for (int n = 0; n < count; n++)
         send_request(MODE_PUT_CURSOR, CHAR_W'($urandom), '0, '0, random_colour());
      idle_on = 1'b1;
   endtask

   initial begin
      for (int k = 0; k < CELLS; k++) begin
         shadow_chars[k]   = CH_SPACE;
         shadow_colours[k] = RESET_DEFAULT_COLOUR;
      end
      shadow_cursor  = 0;
      shadow_default = RESET_DEFAULT_COLOUR;
      shadow_error   = RESET_ERROR_COLOUR;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_colours(8'h1E, 8'hC4);
      test_directed();
      set_colours(8'hFF, 8'h00);
      test_text_lines(28);
      set_colours(8'h00, 8'hFF);
      test_random_mix(350);
      idle_on = 1'b0;
      test_random_mix(150);
      idle_on = 1'b1;
      set_colours(COLOUR_W'($urandom_range(1, 254)), COLOUR_W'($urandom_range(1, 254)));
      test_random_mix(500);
      test_backpressure(60);

      wait_drained();
      repeat (CELLS + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      int stall_len;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            stall_len = idle_on ? $urandom_range(0, 9) : 0;
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && hold_cycles == 0);
      end
   end

   always @(posedge clock) begin
      console_reply_type expected;
      console_reply_type actual;
      if (!reset && rsp_valid && !rsp_stall) begin
         actual = '{rsp_cursor_row, rsp_cursor_col, rsp_cell_char, rsp_cell_colour,
                    rsp_range_error, rsp_scrolled};
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: row %0d col %0d char %h colour %h err %b scr %b",
                        actual.cursor_row, actual.cursor_col, actual.cell_char,
                        actual.cell_colour, actual.range_error, actual.scrolled);
         end else begin
            expected = pending_replies.pop_front();
            if (actual.cursor_row !== expected.cursor_row ||
                actual.cursor_col !== expected.cursor_col ||
                actual.cell_char !== expected.cell_char ||
                actual.cell_colour !== expected.cell_colour ||
                actual.range_error !== expected.range_error ||
                actual.scrolled !== expected.scrolled) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp row %0d col %0d char %h colour %h err %b scr %b, %s",
                           expected.cursor_row, expected.cursor_col, expected.cell_char,
                           expected.cell_colour, expected.range_error, expected.scrolled,
                           $sformatf("got row %0d col %0d char %h colour %h err %b scr %b",
                                     actual.cursor_row, actual.cursor_col, actual.cell_char,
                                     actual.cell_colour, actual.range_error,
                                     actual.scrolled));
            end
         end
      end
   end

endmodule
